// ===== hw/rtl/dupf_pkg.sv =====
// ----------------------------------------------------------------------------
// dupf_pkg
// Shared types and constants of the duplicate alert filter: key layout,
// register indexes, field widths and the position rounding function.
// ----------------------------------------------------------------------------
package dupf_pkg;

  // Number of keys held in the cell ring
  localparam int unsigned DEPTH         = 64;
  // Fraction bits of the incoming positions
  localparam int unsigned POS_FRAC_BITS = 8;

  // Field widths
  localparam int unsigned SNO_W  = 32;
  localparam int unsigned RAW_W  = 32;
  // Rounded position: one bit more than the integer part, so that
  // +2^(RAW_W-F-1) and -2^(RAW_W-F-1) stay distinct
  localparam int unsigned POS_W  = RAW_W + 1 - POS_FRAC_BITS;
  localparam int unsigned ENT_W  = 7;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned MW     = (CNT_W > ENT_W) ? CNT_W : ENT_W;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 8;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 7;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP_PREV   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ENTRIES = 1'd1;

  localparam logic [ENT_W-1:0] MAX_ENTRIES_RST = 7'd64;

  // One stored key
  typedef struct packed {
    logic        [SNO_W-1:0] sno;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } key_t;

  // Per-cycle control of every cell in the ring
  typedef struct packed {
    logic rotate;  // take the key from the next cell
    logic insert;  // take the key from the previous cell
  } cell_ctrl_t;

  // Round a fixed-point position to an integer, halves away from zero.
  // Negative values use ceil((v - half) / 2^F) = (v + half - 1) >>> F.
  function automatic logic signed [POS_W-1:0] round_pos(input logic [RAW_W-1:0] raw);
    logic signed [RAW_W:0] ext;
    logic signed [RAW_W:0] half;
    logic signed [RAW_W:0] adj;
    logic signed [RAW_W:0] sum;
    logic signed [RAW_W:0] shr;
    ext  = $signed({raw[RAW_W-1], raw});
    half = (POS_FRAC_BITS == 0) ? '0 : (RAW_W + 1)'(1) <<< (POS_FRAC_BITS - 1);
    adj  = (POS_FRAC_BITS == 0) ? '0 : (RAW_W + 1)'(raw[RAW_W-1]);
    sum  = ext + half - adj;
    shr  = sum >>> POS_FRAC_BITS;
    return shr[POS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/dupf_cell.sv =====
// ----------------------------------------------------------------------------
// dupf_cell
// One key cell of the ring. Rotates toward the head during a search and
// shifts toward the tail when a new key is pushed in.
// ----------------------------------------------------------------------------
module dupf_cell (
  input  logic               clk_i,
  input  dupf_pkg::cell_ctrl_t ctrl_i,
  input  dupf_pkg::key_t     prev_i,
  input  dupf_pkg::key_t     next_i,
  output dupf_pkg::key_t     data_o
);
  import dupf_pkg::*;

  key_t data_q;

  // Payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.insert) begin
      data_q <= prev_i;
    end else if (ctrl_i.rotate) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/duplicate_alert_filter.sv =====
// ----------------------------------------------------------------------------
// duplicate_alert_filter
// Forwards or drops received alerts by comparing their key against a FIFO
// of recently seen keys held in a ring of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one alert per request, tdata = {pos_y, pos_x,
//   alert_sno}. Output stream m_axis_*: one result per alert, tdata =
//   {entries_held, forward}. Configuration: cfg_we_i / cfg_addr_i /
//   cfg_wdata_i, register 0 loop_prevention, register 1 max_entries; write
//   only while the block is idle.
// Sequence:
//   With loop prevention on, the key is rounded as it is captured, the ring
//   rotates one full turn past the compare at its head cell, and a last step
//   pushes the key and loads the result into the output register. The input
//   reopens as the result is loaded. With loop prevention off, the last step
//   follows the capture directly. One alert is in work at a time.
// Reset:
//   Empties the key store (count zero), loop_prevention = 1, max_entries = 64.
// Stalls:
//   The result waits in the output register; the next alert is accepted
//   meanwhile and holds in its last step until the register frees up.
// ----------------------------------------------------------------------------
module duplicate_alert_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] alert_sno, [63:32] pos_x, [95:64] pos_y
  input  logic [dupf_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // master stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] forward, [7:1] entries_held
  output logic [dupf_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [dupf_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [dupf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import dupf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic              loop_prev_q;
  logic [ENT_W-1:0]  max_entries_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  scan_q;
  logic              hit_q;
  logic              fwd_q;
  key_t              key_q;
  logic              m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  cell_ctrl_t        cell_ctrl;
  key_t              cell_data [DEPTH];

  logic              in_acc;
  logic              out_free;
  logic              head_hit;
  logic              hit_d;
  logic [MW-1:0]     cnt_inc;
  logic [MW-1:0]     cnt_lim;
  logic [CNT_W-1:0]  count_d;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Compare at the head cell, only positions within the held count
  assign head_hit = (scan_q < count_q) && (cell_data[0] == key_q);
  assign hit_d    = hit_q || head_hit;

  // Count after a push: a full store drops its oldest first, then trim to limit
  assign cnt_inc = (count_q == CNT_W'(DEPTH)) ? MW'(count_q) : MW'(count_q) + MW'(1);
  assign cnt_lim = (cnt_inc > MW'(max_entries_q)) ? MW'(max_entries_q) : cnt_inc;
  assign count_d = (state_q == ST_DONE && fwd_q && loop_prev_q) ? cnt_lim[CNT_W-1:0]
                                                                 : count_q;

  // Ring control
  always_comb begin
    cell_ctrl.rotate = (state_q == ST_SCAN);
    cell_ctrl.insert = (state_q == ST_DONE) && out_free && fwd_q && loop_prev_q;
  end

  // Cell ring: cell 0 holds the newest key, cell count-1 the oldest
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t prev_key;
    key_t next_key;
    assign prev_key = (i == 0) ? key_q : cell_data[(i + DEPTH - 1) % DEPTH];
    assign next_key = cell_data[(i + 1) % DEPTH];
    dupf_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .prev_i (prev_key),
      .next_i (next_key),
      .data_o (cell_data[i])
    );
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_prev_q   <= 1'b1;
      max_entries_q <= MAX_ENTRIES_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LOOP_PREV:   loop_prev_q   <= cfg_wdata_i[0];
        REG_MAX_ENTRIES: max_entries_q <= cfg_wdata_i[ENT_W-1:0];
        default: ;
      endcase
    end
  end

  // Incoming key, rounded on acceptance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q.sno <= s_axis_tdata_i[SNO_W-1:0];
      key_q.x   <= round_pos(s_axis_tdata_i[SNO_W+RAW_W-1:SNO_W]);
      key_q.y   <= round_pos(s_axis_tdata_i[SNO_W+2*RAW_W-1:SNO_W+RAW_W]);
    end
  end

  // Sequencer, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      scan_q    <= '0;
      hit_q     <= 1'b0;
      fwd_q     <= 1'b1;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            scan_q  <= '0;
            hit_q   <= 1'b0;
            fwd_q   <= 1'b1;
            state_q <= loop_prev_q ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          hit_q  <= hit_d;
          scan_q <= scan_q + CNT_W'(1);
          if (scan_q == CNT_W'(DEPTH - 1)) begin
            fwd_q   <= !hit_d;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count_q   <= count_d;
            m_valid_q <= 1'b1;
            m_data_q  <= {count_d[ENT_W-1:0], fwd_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== hw/rtl/dupf_checker.sv =====
// ----------------------------------------------------------------------------
// dupf_checker
// Port-level checks of the duplicate alert filter, bound to the top level.
// ----------------------------------------------------------------------------
module dupf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_o,
  input  logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic [dupf_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import dupf_pkg::*;

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Only one alert in work: no request taken right after one was accepted
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second request accepted while busy");

  // Loading a result frees the input side
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("input not ready after result");

  // A dropped alert needs a held key to match
  a_drop_needs_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[7:1] != '0)
    else $error("drop reported with empty store");

endmodule

bind duplicate_alert_filter dupf_checker u_dupf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: duplicate alert filter testbench
// Drives alerts into the filter and compares every verdict with a built-in
// predictor of the key store. The predictor covers position rounding, FIFO
// eviction and the two control registers. Directed tests come first: rounding
// ties, extreme positions, a lowered limit, the filter switched off, a zero
// limit and a long output stall. Random traffic then follows, with repeated
// keys, near misses and full-range values, under a series of settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dupf_pkg::*;

  typedef struct packed {
    logic [6:0] held;
    logic       fwd;
  } verdict_t;

  typedef struct {
    logic [31:0] sno;
    logic [31:0] x;
    logic [31:0] y;
  } alert_t;

  // DUT ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // Predicted key store and registers
  bit                    loop_on;
  int unsigned           keep_limit;
  logic [31:0]           store_sno [DEPTH];
  longint                store_x [DEPTH];
  longint                store_y [DEPTH];
  int unsigned           store_head;
  int unsigned           store_held;

  verdict_t              verdict_q [$];
  alert_t                recent_q [$];

  int unsigned           err_cnt;
  int unsigned           n_fwd;
  int unsigned           n_drop;
  int unsigned           peak_held;
  bit                    steady;
  int unsigned           hold_req;
  int unsigned           hold_left;

  duplicate_alert_filter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Fixed point to integer, halves away from zero
  function automatic longint round_fix(input logic [31:0] raw);
    longint v;
    longint mag;
    v = longint'($signed(raw));
    if (POS_FRAC_BITS == 0) return v;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (POS_FRAC_BITS - 1))) >>> POS_FRAC_BITS;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic void drop_oldest();
    if (store_held == 0) return;
    store_head = (store_head + 1) % DEPTH;
    store_held--;
  endfunction

  // Verdict for one alert; updates the predicted store
  function automatic verdict_t filter_alert(input logic [31:0] sno,
                                            input logic [31:0] px,
                                            input logic [31:0] py);
    verdict_t    v;
    longint      xq;
    longint      yq;
    int unsigned s;
    xq    = round_fix(px);
    yq    = round_fix(py);
    v.fwd = 1'b1;
    if (loop_on) begin
      for (int unsigned i = 0; i < store_held; i++) begin
        s = (store_head + i) % DEPTH;
        if (store_sno[s] == sno && store_x[s] == xq && store_y[s] == yq) v.fwd = 1'b0;
      end
      if (v.fwd) begin
        if (store_held >= DEPTH) drop_oldest();
        s = (store_head + store_held) % DEPTH;
        store_sno[s] = sno;
        store_x[s]   = xq;
        store_y[s]   = yq;
        store_held++;
        while (store_held > keep_limit) drop_oldest();
      end
    end
    v.held = 7'(store_held);
    return v;
  endfunction

  // Random raw position that rounds to the same integer as raw
  function automatic logic [31:0] jitter_pos(input logic [31:0] raw);
    longint r;
    longint unit;
    longint half;
    longint lo;
    longint hi;
    r    = round_fix(raw);
    unit = longint'(1) << POS_FRAC_BITS;
    half = unit / 2;
    if (r > 0) begin
      lo = r * unit - half;
      hi = r * unit + half - 1;
    end else if (r < 0) begin
      lo = r * unit - half + 1;
      hi = r * unit + half;
    end else begin
      lo = -(half - 1);
      hi = half - 1;
    end
    if (lo < -64'sd2147483648) lo = -64'sd2147483648;
    if (hi > 64'sd2147483647) hi = 64'sd2147483647;
    return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  // Predict on every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      verdict_q.insert(verdict_q.size(),
                       filter_alert(s_axis_tdata_i[31:0], s_axis_tdata_i[63:32],
                                    s_axis_tdata_i[95:64]));
    end
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (verdict_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: unexpected result fwd=%0d held=%0d",
                                    got.fwd, got.held);
      end else begin
        want = verdict_q[0];
        verdict_q.delete(0);
        if (got.fwd !== want.fwd) begin
          err_cnt++;
          if (err_cnt <= 10) $display("ERROR: forward exp %0d got %0d", want.fwd, got.fwd);
        end
        if (got.held !== want.held) begin
          err_cnt++;
          if (err_cnt <= 10) $display("ERROR: entries_held exp %0d got %0d",
                                      want.held, got.held);
        end
        if (want.fwd) n_fwd++;
        else n_drop++;
        if (want.held > peak_held) peak_held = want.held;
      end
    end
  end

  // Result side: random stalls, steady stretches and requested long holds
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (steady) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= 36);
    end
  end

  // Offer one alert and wait until it is taken
  task automatic send_alert(input logic [31:0] sno, input logic [31:0] px,
                            input logic [31:0] py);
    alert_t a;
    while (!steady && $urandom_range(99) < 36) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    if (!steady && $urandom_range(9) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {py, px, sno};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    a.sno = sno;
    a.x   = px;
    a.y   = py;
    recent_q.insert(recent_q.size(), a);
    if (recent_q.size() > 80) recent_q.delete(0);
  endtask

  // Stop offering and wait until every verdict is back
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == REG_LOOP_PREV) loop_on = value[0];
    else keep_limit = value & 7'h7f;
  endtask

  // Rounding ties, bucket aliasing and full-scale positions
  task automatic test_rounding();
    send_alert(32'd1, 32'h0000_0080, 32'h0);  // +0.5 -> 1
    send_alert(32'd1, 32'h0000_017F, 32'h0);  // 1.496 -> 1, repeat
    send_alert(32'd1, 32'h0000_007F, 32'h0);  // just under half -> 0
    send_alert(32'd1, 32'hFFFF_FF80, 32'h0);  // -0.5 -> -1
    send_alert(32'd1, 32'hFFFF_FF81, 32'h0);  // -0.496 -> 0, repeat
    send_alert(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_alert(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_alert(32'hFFFF_FFFF, 32'h7FFF_FF80, 32'h8000_0080);  // same key as two lines up
    send_alert(32'd0, 32'h0, 32'h0);
  endtask

  // Lowering the limit evicts nothing until the next insertion
  task automatic test_limit_lowered();
    write_reg(REG_MAX_ENTRIES, 2);
    send_alert(32'd0, 32'h0, 32'h0);
    send_alert(32'd2, 32'h0000_0100, 32'hFFFF_FF00);
  endtask

  // Filter off: everything forwarded, store left alone
  task automatic test_loop_off();
    write_reg(REG_LOOP_PREV, 0);
    send_alert(32'd2, 32'h0000_0100, 32'hFFFF_FF00);
    send_alert(32'd2, 32'h0000_0100, 32'hFFFF_FF00);
    write_reg(REG_LOOP_PREV, 1);
  endtask

  // Zero limit: insert and evict at once
  task automatic test_zero_limit();
    write_reg(REG_MAX_ENTRIES, 0);
    send_alert(32'd7, 32'h0, 32'h0);
    send_alert(32'd7, 32'h0, 32'h0);
  endtask

  // Long output stall while alerts keep coming
  task automatic test_backpressure();
    write_reg(REG_MAX_ENTRIES, 64);
    hold_req = 400;
    for (int i = 0; i < 5; i++) send_alert(32'(100 + i), $urandom, $urandom);
  endtask

  // Random traffic in phases with varied settings
  task automatic test_random_traffic();
    int unsigned limits [10];
    int unsigned c;
    alert_t      k;
    logic [31:0] sno;
    logic [31:0] px;
    logic [31:0] py;
    limits = '{64, 127, 5, 0, 1, 63, 65, 20, 127, 2};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_LOOP_PREV, (ph == 6) ? 0 : 1);
      write_reg(REG_MAX_ENTRIES, limits[ph]);
      steady = (ph == 2);
      for (int n = 0; n < 155; n++) begin
        c = $urandom_range(99);
        if (recent_q.size() != 0 && c < 70) begin
          k   = recent_q[$urandom_range(recent_q.size() - 1)];
          sno = k.sno;
          px  = jitter_pos(k.x);
          py  = jitter_pos(k.y);
          // near miss: one component one step off
          if (c >= 55) begin
            case ($urandom_range(2))
              0:       sno = sno + 1;
              1:       px  = px + 32'h100;
              default: py  = py - 32'h100;
            endcase
          end
        end else if (c < 90) begin
          sno = $urandom_range(15);
          px  = 32'($urandom_range(8191)) - 32'd4096;
          py  = 32'($urandom_range(8191)) - 32'd4096;
        end else begin
          sno = $urandom;
          px  = $urandom;
          py  = $urandom;
        end
        send_alert(sno, px, py);
      end
      steady = 1'b0;
    end
  endtask

  // Test sequence
  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    m_axis_tready_i <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_addr_i      <= '0;
    cfg_wdata_i     <= '0;
    loop_on    = 1'b1;
    keep_limit = MAX_ENTRIES_RST;
    store_head = 0;
    store_held = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rounding();
    test_limit_lowered();
    test_loop_off();
    test_zero_limit();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (100) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      err_cnt++;
      $display("ERROR: %0d verdicts never arrived", verdict_q.size());
    end
    $display("Checked %0d verdicts: %0d forwarded, %0d dropped, peak store %0d keys",
             n_fwd + n_drop, n_fwd, n_drop, peak_held);
    $display("Covered rounding ties, full-range keys, filter on/off, limits 0 to 127, stalls");
    if (err_cnt == 0) begin
      $display("PASS duplicate_alert_filter");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("FAIL duplicate_alert_filter");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("ERROR: timeout");
    $display("FAIL duplicate_alert_filter");
    $finish;
  end

endmodule
